FILE: hw/rtl/uniform_step_quantizer_assert.svh
// Assertion macros used by the quantizer top level.
`ifndef UNIFORM_STEP_QUANTIZER_ASSERT_SVH
`define UNIFORM_STEP_QUANTIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define USQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define USQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/usq_pkg.sv
// Shared widths, beat type and level helpers for the step quantizer.
`timescale 1ns / 1ps

package usq_pkg;

  localparam int unsigned SampleW      = 32;
  localparam int unsigned StepW        = 32;
  localparam int unsigned MaxLevelBits = 16;
  localparam int unsigned LevelBitsW   = 5;
  localparam int unsigned IndexW       = 16;
  localparam int unsigned AmpW         = 49;

  // One quotient bit per cell; the top bit only flags saturation.
  localparam int unsigned QuotW    = MaxLevelBits + 1;
  localparam int unsigned NumCells = QuotW;
  // Remainder and divisor span step << MaxLevelBits; offset sample is one bit wider.
  localparam int unsigned RemW     = StepW + MaxLevelBits;
  localparam int unsigned OffW     = RemW + 1;
  localparam int unsigned CoefW    = QuotW + 2;

  localparam logic [LevelBitsW-1:0] LevelBitsReset = LevelBitsW'(8);

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RemW-1:0]  dvs;
    logic [StepW-1:0] step;
    logic [QuotW-1:0] quot;
    logic             neg;
    logic             err;
  } div_beat_t;

  // Saturate the register to 1..MaxLevelBits.
  function automatic logic [LevelBitsW-1:0] eff_bits(input logic [LevelBitsW-1:0] raw);
    logic [LevelBitsW-1:0] b;
    b = raw;
    if (b == '0) begin
      b = LevelBitsW'(1);
    end else if (b > LevelBitsW'(MaxLevelBits)) begin
      b = LevelBitsW'(MaxLevelBits);
    end
    return b;
  endfunction

  // Highest level index, 2^bits - 1.
  function automatic logic [QuotW-1:0] level_max(input logic [LevelBitsW-1:0] raw);
    return (QuotW'(1) << eff_bits(raw)) - QuotW'(1);
  endfunction

endpackage

FILE: hw/rtl/uniform_step_quantizer.sv
// Top level of the uniform midrise quantizer with per-beat step size.
`timescale 1ns / 1ps

// Takes one sample/step beat per clock and returns one result beat per clock while
// out_ready_i is high. Each beat passes a front stage, a row of 17 division cells (one
// quotient bit each, restoring compare and subtract on a 48-bit remainder) and an exit
// stage with a 19x33 multiplier. That is 19 register stages: front, cells and exit.
// A stall at the output holds only the stages that are full; empty stages still take beats.
// level_bits is written through cfg_we_i/cfg_wdata_i; the user must write it only while no
// beat is in flight, which the block does not enforce. It is saturated to 1..16.
// A zero step gives step_error_o with index and amplitude at zero.
module uniform_step_quantizer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [usq_pkg::LevelBitsW-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [usq_pkg::SampleW-1:0] sample_value_i,
  input  logic [usq_pkg::StepW-1:0]         step_size_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [usq_pkg::IndexW-1:0]        level_index_o,
  output logic signed [usq_pkg::AmpW-1:0]   amplitude_o,
  output logic [usq_pkg::StepW-1:0]         step_out_o,
  output logic                              step_error_o
);

  `include "uniform_step_quantizer_assert.svh"

  logic [usq_pkg::LevelBitsW-1:0] level_bits_q;
  logic [usq_pkg::QuotW-1:0]      lmax_chk;

  usq_pkg::div_beat_t beat [usq_pkg::NumCells+1];
  logic               vld  [usq_pkg::NumCells+1];
  logic               rdy  [usq_pkg::NumCells+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_bits_q <= usq_pkg::LevelBitsReset;
    end else if (cfg_we_i) begin
      level_bits_q <= cfg_wdata_i;
    end
  end

  usq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .level_bits_i (level_bits_q),
    .valid_i      (in_valid_i),
    .ready_o      (in_ready_o),
    .sample_i     (sample_value_i),
    .step_i       (step_size_i),
    .valid_o      (vld[0]),
    .ready_i      (rdy[0]),
    .beat_o       (beat[0])
  );

  for (genvar c = 0; c < usq_pkg::NumCells; c++) begin : g_cell
    usq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[c]),
      .ready_o (rdy[c]),
      .beat_i  (beat[c]),
      .valid_o (vld[c+1]),
      .ready_i (rdy[c+1]),
      .beat_o  (beat[c+1])
    );
  end

  usq_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .level_bits_i  (level_bits_q),
    .valid_i       (vld[usq_pkg::NumCells]),
    .ready_o       (rdy[usq_pkg::NumCells]),
    .beat_i        (beat[usq_pkg::NumCells]),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .level_index_o (level_index_o),
    .amplitude_o   (amplitude_o),
    .step_out_o    (step_out_o),
    .step_error_o  (step_error_o)
  );

  assign lmax_chk = usq_pkg::level_max(level_bits_q);

  `USQ_ASSERT_NEXT(a_entry_lands, in_valid_i && in_ready_o, vld[0],
                   "accepted beat did not reach the front stage")
  `USQ_ASSERT_IMPLY(a_err_zeroes, out_valid_o && step_error_o,
                    level_index_o == '0 && amplitude_o == '0,
                    "error beat carries a nonzero index or amplitude")
  `USQ_ASSERT_IMPLY(a_err_iff_zero, out_valid_o,
                    step_error_o == (step_out_o == '0),
                    "error flag disagrees with the passed-through step")
  `USQ_ASSERT_IMPLY(a_index_range, out_valid_o && !step_error_o,
                    usq_pkg::QuotW'(level_index_o) <= lmax_chk,
                    "level index beyond the configured range")

endmodule

FILE: hw/rtl/usq_front.sv
// Entry stage: shifts the sample up by half the level range and sets up the divisor.
`timescale 1ns / 1ps

module usq_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [usq_pkg::LevelBitsW-1:0]      level_bits_i,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic signed [usq_pkg::SampleW-1:0]  sample_i,
  input  logic [usq_pkg::StepW-1:0]           step_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output usq_pkg::div_beat_t                  beat_o
);

  logic [usq_pkg::LevelBitsW-1:0] half_sh;
  logic [usq_pkg::RemW-1:0]       half_off;
  logic signed [usq_pkg::OffW-1:0] off_sum;
  usq_pkg::div_beat_t             beat_d, beat_q;
  logic                           valid_q;

  // sample + step * L/2, exact in the wide signed domain
  assign half_sh  = usq_pkg::eff_bits(level_bits_i) - usq_pkg::LevelBitsW'(1);
  assign half_off = usq_pkg::RemW'(step_i) << half_sh;
  assign off_sum  = $signed({{(usq_pkg::OffW - usq_pkg::SampleW){sample_i[usq_pkg::SampleW-1]}},
                             sample_i})
                  + $signed({1'b0, half_off});

  always_comb begin
    beat_d      = '0;
    beat_d.rem  = off_sum[usq_pkg::RemW-1:0];
    beat_d.neg  = off_sum[usq_pkg::OffW-1];
    beat_d.dvs  = usq_pkg::RemW'(step_i) << usq_pkg::MaxLevelBits;
    beat_d.step = step_i;
    beat_d.quot = '0;
    beat_d.err  = (step_i == '0);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

FILE: hw/rtl/usq_cell.sv
// Division cell: one restoring quotient bit per beat, divisor halves on the way out.
`timescale 1ns / 1ps

module usq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  usq_pkg::div_beat_t beat_i,
  output logic               valid_o,
  input  logic               ready_i,
  output usq_pkg::div_beat_t beat_o
);

  logic               fits;
  usq_pkg::div_beat_t beat_d, beat_q;
  logic               valid_q;

  assign fits = (beat_i.rem >= beat_i.dvs);

  always_comb begin
    beat_d      = beat_i;
    beat_d.rem  = fits ? (beat_i.rem - beat_i.dvs) : beat_i.rem;
    beat_d.dvs  = beat_i.dvs >> 1;
    beat_d.quot = {beat_i.quot[usq_pkg::QuotW-2:0], fits};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

FILE: hw/rtl/usq_back.sv
// Exit stage: clamps the quotient to the level range and rebuilds the amplitude.
`timescale 1ns / 1ps

module usq_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [usq_pkg::LevelBitsW-1:0]    level_bits_i,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  usq_pkg::div_beat_t                beat_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [usq_pkg::IndexW-1:0]        level_index_o,
  output logic signed [usq_pkg::AmpW-1:0]   amplitude_o,
  output logic [usq_pkg::StepW-1:0]         step_out_o,
  output logic                              step_error_o
);

  logic [usq_pkg::QuotW-1:0]                    lmax;
  logic [usq_pkg::QuotW-1:0]                    k;
  logic signed [usq_pkg::CoefW-1:0]             coef;
  logic signed [usq_pkg::CoefW+usq_pkg::StepW:0] prod;
  logic                                         valid_q;
  logic [usq_pkg::IndexW-1:0]                   index_q;
  logic signed [usq_pkg::AmpW-1:0]              amp_q;
  logic [usq_pkg::StepW-1:0]                    step_q;
  logic                                         err_q;

  assign lmax = usq_pkg::level_max(level_bits_i);

  // An error or below-range beat reads as level 0; the saturation bit or a large quotient pins the top.
  always_comb begin
    if (beat_i.err || beat_i.neg) begin
      k = '0;
    end else if (beat_i.quot > lmax) begin
      k = lmax;
    end else begin
      k = beat_i.quot;
    end
  end

  // (2k - L + 1) * step, read with 1 fractional bit
  assign coef = $signed({1'b0, k, 1'b0}) - $signed({2'b00, lmax});
  assign prod = coef * $signed({1'b0, beat_i.step});

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      index_q <= k[usq_pkg::IndexW-1:0];
      amp_q   <= beat_i.err ? '0 : prod[usq_pkg::AmpW-1:0];
      step_q  <= beat_i.step;
      err_q   <= beat_i.err;
    end
  end

  assign valid_o       = valid_q;
  assign level_index_o = index_q;
  assign amplitude_o   = amp_q;
  assign step_out_o    = step_q;
  assign step_error_o  = err_q;

endmodule
